/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL top level.
// Needs no package; the user names clock and reset at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising edge outside reset.
`define CHK_HOLDS(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Overlapping implication checked on every rising edge outside reset.
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/srgbp_pkg.sv */
// Package for the sRGB linear-light alpha premultiply block.
// Holds pixel types, sizes and the elaboration-time table builders.
`timescale 1ns / 1ps
`default_nettype none

package srgbp_pkg;

  localparam int LINEAR_FRAC_BITS_DEF = 16;
  localparam int NUM_COLORS = 3;
  localparam int CODE_W = 8;
  localparam int CODE_LEVELS = 256;
  localparam int CODE_MAX = 255;
  localparam int COLOR_LATENCY = 4 + CODE_W;
  localparam int BIG_W = 384;
  localparam int SEARCH_ITERS = 32;
  localparam logic [CODE_W-1:0] OPAQUE = 8'hFF;

  typedef logic [BIG_W-1:0] big_t;
  typedef logic [63:0] wide_t;
  typedef logic [NUM_COLORS-1:0][CODE_W-1:0] codes_t;

  typedef struct packed {
    logic [CODE_W-1:0] red_in;
    logic [CODE_W-1:0] green_in;
    logic [CODE_W-1:0] blue_in;
    logic [CODE_W-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] red_out;
    logic [CODE_W-1:0] green_out;
    logic [CODE_W-1:0] blue_out;
    logic [CODE_W-1:0] alpha_out;
  } pix_out_t;

  function automatic wide_t lin_max_of(int fb);
    return (wide_t'(1) << fb) - wide_t'(1);
  endfunction

  // a^ea * b^eb, exact
  function automatic big_t big_pow2(wide_t a, int ea, wide_t b, int eb);
    big_t r;
    r = big_t'(1);
    for (int i = 0; i < ea; i++) r = r * big_t'(a);
    for (int i = 0; i < eb; i++) r = r * big_t'(b);
    return r;
  endfunction

  // true when lv - 0.5 <= S * ((c + 14.025) / 269.025)^2.4
  function automatic logic dec_ok(int fb, wide_t c, wide_t lv);
    wide_t lm;
    big_t lhs;
    big_t rhs;
    lm = lin_max_of(fb);
    if (lv == wide_t'(0)) return 1'b1;
    lhs = big_pow2(wide_t'(2) * lv - wide_t'(1), 5, wide_t'(269025), 12);
    rhs = big_pow2(wide_t'(2) * lm, 5, wide_t'(1000) * c + wide_t'(14025), 12);
    return lhs <= rhs;
  endfunction

  // true when 255 * enc(p / S) >= k - 0.5
  function automatic logic enc_ok(int fb, wide_t p, wide_t k);
    wide_t lm;
    big_t lhs;
    big_t rhs;
    lm = lin_max_of(fb);
    if (p * wide_t'(10000000) <= wide_t'(31308) * lm)
      return wide_t'(65892) * p >=
             wide_t'(10) * (wide_t'(2) * k - wide_t'(1)) * lm;
    lhs = big_pow2(p, 5, wide_t'(53805), 12);
    rhs = big_pow2(wide_t'(200) * k + wide_t'(2705), 12, lm, 5);
    return lhs >= rhs;
  endfunction

  // linear value of an sRGB code; the linear segment takes the floor of
  // (200 * S * c + 329460) / 658920 by the same search
  function automatic wide_t dec_entry(int fb, wide_t c);
    wide_t lm;
    wide_t lo;
    wide_t hi;
    wide_t mid;
    wide_t num;
    logic  ok;
    lm = lin_max_of(fb);
    num = wide_t'(200) * lm * c + wide_t'(329460);
    lo = '0;
    hi = lm;
    for (int it = 0; it < SEARCH_ITERS; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + wide_t'(1)) >> 1);
        if (c <= wide_t'(10)) ok = (mid * wide_t'(658920) <= num);
        else ok = dec_ok(fb, c, mid);
        if (ok) lo = mid;
        else hi = mid - wide_t'(1);
      end
    end
    return lo;
  endfunction

  // least linear value that encodes to code k or above
  function automatic wide_t enc_entry(int fb, wide_t k);
    wide_t lo;
    wide_t hi;
    wide_t mid;
    if (k == wide_t'(0)) return '0;
    lo = '0;
    hi = lin_max_of(fb);
    for (int it = 0; it < SEARCH_ITERS; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (enc_ok(fb, mid, k)) hi = mid;
        else lo = mid + wide_t'(1);
      end
    end
    return lo;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/srgbp_color.sv */
// Color datapath: sRGB decode, alpha multiply, divide by 255, sRGB encode.
// Three lanes, COLOR_LATENCY register stages, no stall; uses srgbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srgbp_color #(
  parameter int LINEAR_FRAC_BITS = srgbp_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire srgbp_pkg::codes_t                 code,
  input  wire logic [srgbp_pkg::CODE_W-1:0]      alpha,
  output srgbp_pkg::codes_t                      level
);

  localparam int LinW = LINEAR_FRAC_BITS;
  localparam int CodeW = srgbp_pkg::CODE_W;
  localparam int NumColors = srgbp_pkg::NUM_COLORS;
  localparam int CodeLevels = srgbp_pkg::CODE_LEVELS;
  localparam int ProdW = LinW + CodeW;
  localparam int RecipW = 8 * ((ProdW + 7) / 8);
  localparam int MulW = ProdW + RecipW;
  localparam int EncSteps = CodeW;
  localparam int ChanMax = srgbp_pkg::CODE_MAX;
  localparam int RoundBias = (ChanMax - 1) / 2;
  localparam logic [RecipW-1:0] Recip = {(RecipW / 8){8'h01}};

  logic [LinW-1:0] dec_rom [CodeLevels];
  logic [LinW-1:0] thr_rom [CodeLevels];

  for (genvar gc = 0; gc < CodeLevels; gc++) begin : g_rom
    localparam logic [LinW-1:0] DecVal =
      LinW'(srgbp_pkg::dec_entry(LINEAR_FRAC_BITS, srgbp_pkg::wide_t'(gc)));
    localparam logic [LinW-1:0] ThrVal =
      LinW'(srgbp_pkg::enc_entry(LINEAR_FRAC_BITS, srgbp_pkg::wide_t'(gc)));
    assign dec_rom[gc] = DecVal;
    assign thr_rom[gc] = ThrVal;
  end

  logic [LinW-1:0]   s1_lin [NumColors];
  logic [CodeW-1:0]  s1_alpha;
  logic [ProdW-1:0]  s2_y [NumColors];
  logic [MulW-1:0]   s3_m [NumColors];
  logic [ProdW-1:0]  s3_y [NumColors];
  logic [LinW-1:0]   s4_p [NumColors];
  logic [ProdW-1:0]  quot [NumColors];
  logic [ProdW-1:0]  rem [NumColors];
  logic [LinW-1:0]   s4_p_next [NumColors];
  logic [LinW-1:0]   sr_p [EncSteps-1][NumColors];
  logic [CodeW-1:0]  sr_n [EncSteps][NumColors];

  // decode
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumColors; i++) begin
      s1_lin[i] <= dec_rom[code[i]];
    end
    s1_alpha <= alpha;
  end

  // multiply, add rounding bias
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumColors; i++) begin
      s2_y[i] <= ProdW'(s1_lin[i]) * ProdW'(s1_alpha) + ProdW'(RoundBias);
    end
  end

  // reciprocal multiply
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumColors; i++) begin
      s3_m[i] <= MulW'(s2_y[i]) * MulW'(Recip);
      s3_y[i] <= s2_y[i];
    end
  end

  // correct quotient by one
  always_comb begin
    for (int i = 0; i < NumColors; i++) begin
      quot[i] = s3_m[i][MulW-1:RecipW];
      rem[i] = s3_y[i] - ProdW'(quot[i] * ProdW'(ChanMax));
      s4_p_next[i] = quot[i][LinW-1:0] + LinW'(rem[i] >= ProdW'(ChanMax));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumColors; i++) begin
      s4_p[i] <= s4_p_next[i];
    end
  end

  // encode: one threshold compare per stage, MSB first
  for (genvar gs = 0; gs < EncSteps; gs++) begin : g_step
    localparam int BitPos = EncSteps - 1 - gs;
    logic [LinW-1:0]  p_in [NumColors];
    logic [CodeW-1:0] n_in [NumColors];
    logic [CodeW-1:0] cand [NumColors];

    for (genvar gl = 0; gl < NumColors; gl++) begin : g_lane
      if (gs == 0) begin : g_first
        assign p_in[gl] = s4_p[gl];
        assign n_in[gl] = '0;
      end else begin : g_next
        assign p_in[gl] = sr_p[gs-1][gl];
        assign n_in[gl] = sr_n[gs-1][gl];
      end
      assign cand[gl] = n_in[gl] | ({{(CodeW-1){1'b0}}, 1'b1} << BitPos);
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < NumColors; i++) begin
        sr_n[gs][i] <= (p_in[i] >= thr_rom[cand[i]]) ? cand[i] : n_in[i];
      end
    end

    if (gs < EncSteps - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        for (int i = 0; i < NumColors; i++) begin
          sr_p[gs][i] <= p_in[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumColors; i++) begin
      level[i] = sr_n[EncSteps-1][i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srgb_linear_alpha_premultiply.sv */
// Top level: sRGB RGBA premultiply by alpha in linear light.
// Uses srgbp_pkg, srgbp_color and assert_macros.svh.
//
//   port    dir  payload     handshake
//   pixel   in   pix_in_t    taken when start is high and busy is low
//   result  out  pix_out_t   valid for one cycle while done is high
//
// One item per clock; busy stays low. A result passes through one decode
// table stage, one multiply, two stages for the divide by 255, eight threshold
// search stages, and the output register. rst clears the valid pipeline and
// done; items in flight are dropped. The receiver cannot stall, so the
// pipeline always advances.
`timescale 1ns / 1ps
`default_nettype none

module srgb_linear_alpha_premultiply #(
  parameter int LINEAR_FRAC_BITS = srgbp_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire srgbp_pkg::pix_in_t  pixel,
  output logic                     done,
  output srgbp_pkg::pix_out_t      result
);

`include "assert_macros.svh"

  localparam int Lat = srgbp_pkg::COLOR_LATENCY;
  localparam int OutLat = Lat + 1;

  logic                   accept;
  logic [Lat-1:0]         valid_pipe;
  srgbp_pkg::pix_in_t     pix_dly [Lat];
  srgbp_pkg::codes_t      codes;
  srgbp_pkg::codes_t      levels;
  srgbp_pkg::pix_in_t     tail;
  srgbp_pkg::pix_out_t    result_next;
  logic                   opaque;

  assign busy = 1'b0;
  assign accept = start & ~busy;

  assign codes[0] = pixel.red_in;
  assign codes[1] = pixel.green_in;
  assign codes[2] = pixel.blue_in;

  srgbp_color #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
  ) u_color (
    .clk  (clk),
    .code (codes),
    .alpha(pixel.alpha_in),
    .level(levels)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
      done <= 1'b0;
    end else begin
      valid_pipe <= {valid_pipe[Lat-2:0], accept};
      done <= valid_pipe[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    pix_dly[0] <= pixel;
    for (int s = 1; s < Lat; s++) begin
      pix_dly[s] <= pix_dly[s-1];
    end
    result <= result_next;
  end

  always_comb begin
    tail = pix_dly[Lat-1];
    opaque = (tail.alpha_in == srgbp_pkg::OPAQUE);
    result_next.red_out = opaque ? tail.red_in : levels[0];
    result_next.green_out = opaque ? tail.green_in : levels[1];
    result_next.blue_out = opaque ? tail.blue_in : levels[2];
    result_next.alpha_out = tail.alpha_in;
  end

  `CHK_IMPLY(a_done_has_item, clk, rst, done, $past(accept, OutLat), "result without an item")
  `CHK_IMPLY(a_alpha_kept, clk, rst, done, result.alpha_out == $past(pixel.alpha_in, OutLat), "alpha changed")
  `CHK_IMPLY(a_opaque_kept, clk, rst, done && result.alpha_out == srgbp_pkg::OPAQUE, result.red_out == $past(pixel.red_in, OutLat) && result.green_out == $past(pixel.green_in, OutLat) && result.blue_out == $past(pixel.blue_in, OutLat), "opaque item altered")
  `CHK_IMPLY(a_clear_black, clk, rst, done && result.alpha_out == '0, result.red_out == '0 && result.green_out == '0 && result.blue_out == '0, "clear item not black")
  `CHK_HOLDS(a_never_busy, clk, rst, !busy, "busy raised")

endmodule

`default_nettype wire
